// ----- rtl/mvm_pkg.sv -----
// Package for the streaming matrix-vector multiplier.
// Holds widths, codes, reset values and the pipeline control struct.
`timescale 1ns / 1ps
package mvm_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int MAX_DIM_DEF = 8;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_MATRIX = 1'b1;

  localparam logic REG_DIM = 1'b0;

  typedef struct packed {
    logic             vld;
    logic             row_end;
    logic             last;
    logic [IDX_W-1:0] row;
  } mvm_ctl_t;

endpackage

// ----- rtl/mvm_mac.sv -----
// Multiply-accumulate back end: product stage, then row and total accumulators.
// Depends on mvm_pkg for widths and the control struct.
`timescale 1ns / 1ps
module mvm_mac
  import mvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  mvm_ctl_t          ctl,
  input  logic [DATA_W-1:0] elem,
  input  logic [DATA_W-1:0] vec,
  output logic              res_valid,
  output logic [IDX_W-1:0]  res_row,
  output logic [DATA_W-1:0] res_dot,
  output logic [DATA_W-1:0] res_total,
  output logic              res_last
);

  mvm_ctl_t          ctl_r;
  logic [DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] tot_r, tot_nxt;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] tot_sum;
  logic              valid_r;
  logic [IDX_W-1:0]  row_r;
  logic [DATA_W-1:0] dot_r;
  logic [DATA_W-1:0] total_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= DATA_W'(elem * vec);
  end

  assign sum     = acc_r + prod_r;
  assign tot_sum = tot_r + sum;

  always_comb begin
    acc_nxt = acc_r;
    tot_nxt = tot_r;
    if (clr) begin
      acc_nxt = '0;
      tot_nxt = '0;
    end else if (ctl_r.vld) begin
      if (ctl_r.row_end) begin
        acc_nxt = '0;
        tot_nxt = ctl_r.last ? '0 : tot_sum;
      end else begin
        acc_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      tot_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      tot_r   <= tot_nxt;
      valid_r <= ctl_r.vld & ctl_r.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_r.vld && ctl_r.row_end) begin
      row_r   <= ctl_r.row;
      dot_r   <= sum;
      total_r <= tot_sum;
      last_r  <= ctl_r.last;
    end
  end

  assign res_valid = valid_r;
  assign res_row   = row_r;
  assign res_dot   = dot_r;
  assign res_total = total_r;
  assign res_last  = last_r;

endmodule

// ----- rtl/matrix_vector_multiply_top.sv -----
// Streaming matrix-vector multiplier, top level.
// Depends on mvm_pkg and mvm_mac; holds the vector memory and row/column counters.
//
// Usage:
//  - Input: a transaction is taken when start is high and busy is low. busy stays
//    low, so one element is taken every cycle. in_func = 0 writes in_value into
//    vector entry in_vector_index; in_func = 1 streams the next matrix element,
//    row-major.
//  - Each matrix element reads the vector memory (one synchronous read port),
//    is multiplied in the next stage and accumulated in the third.
//  - Output: when a row completes, out_valid pulses for one cycle after the vector
//    read, product and result registers, with row index, dot product, running
//    total and a last-row flag. The receiver cannot stall; results are never held.
//  - Throughput: one element per cycle, set by the single memory read port and
//    the three-stage multiply-accumulate pipeline.
//  - Configuration: register dim_n at byte address 0 (reset 8). A write clears
//    the row and column position, accumulator and running total; write only
//    while no row is in flight.
//  - Reset (rst_n low, synchronous) clears counters and accumulators and sets
//    dim_n to 8. Vector entries are undefined until loaded.
`timescale 1ns / 1ps
module matrix_vector_multiply_top
  import mvm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [IDX_W-1:0]  in_vector_index,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_row_index,
  output logic [DATA_W-1:0] out_dot_product,
  output logic [DATA_W-1:0] out_total_sum,
  output logic              out_last_row,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0]  dim_r;
  logic              cfg_wr;
  logic [DW-1:0]     act_dim;
  logic              accept;
  logic              mat_acc;
  logic              vec_wr;
  logic [AW-1:0]     col_r, col_nxt;
  logic [AW-1:0]     row_r, row_nxt;
  logic [AW:0]       col_p1;
  logic [AW:0]       row_p1;
  logic              row_end;
  logic              last;
  logic [DATA_W-1:0] vec_mem [MAX_DIM];
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] elem_r;
  mvm_ctl_t          ctl_r, ctl_nxt;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr[2] == REG_DIM);
  assign cfg_prdata = (cfg_paddr[2] == REG_DIM) ? {{(32-DIM_W){1'b0}}, dim_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_wr) begin
      dim_r <= cfg_pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    if (dim_r == '0) begin
      act_dim = DW'(1);
    end else if (32'(dim_r) > 32'(MAX_DIM)) begin
      act_dim = DW'(MAX_DIM);
    end else begin
      act_dim = DW'(dim_r);
    end
  end

  // input transaction
  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign mat_acc = accept & (in_func == FUNC_MATRIX);
  assign vec_wr  = accept & (in_func == FUNC_LOAD) &
                   (32'(in_vector_index) < 32'(MAX_DIM));

  assign col_p1  = (AW+1)'(col_r) + (AW+1)'(1);
  assign row_p1  = (AW+1)'(row_r) + (AW+1)'(1);
  assign row_end = col_p1 >= (AW+1)'(act_dim);
  assign last    = row_p1 >= (AW+1)'(act_dim);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (mat_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last ? '0 : AW'(row_p1);
      end else begin
        col_nxt = AW'(col_p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ctl_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_comb begin
    ctl_nxt.vld     = mat_acc;
    ctl_nxt.row_end = row_end;
    ctl_nxt.last    = last;
    ctl_nxt.row     = IDX_W'(row_r);
  end

  // vector memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (vec_wr) begin
      vec_mem[AW'(in_vector_index)] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= vec_mem[col_r];
    elem_r    <= in_value;
  end

  mvm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_wr),
    .ctl       (ctl_r),
    .elem      (elem_r),
    .vec       (rd_data_r),
    .res_valid (out_valid),
    .res_row   (out_row_index),
    .res_dot   (out_dot_product),
    .res_total (out_total_sum),
    .res_last  (out_last_row)
  );

endmodule

// ----- rtl/mvm_checker.sv -----
// Port-level checker for the matrix-vector multiplier, bound to the top level.
// Depends on mvm_pkg for field widths and codes.
`timescale 1ns / 1ps
module mvm_checker
  import mvm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_func,
  input logic              out_valid,
  input logic [IDX_W-1:0]  out_row_index,
  input logic [DATA_W-1:0] out_dot_product,
  input logic [DATA_W-1:0] out_total_sum,
  input logic              cfg_pready
);

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_func == FUNC_MATRIX, 3))
    else $error("result without a matrix transaction three cycles earlier");

  a_first_row_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_index == '0 |-> out_total_sum == out_dot_product)
    else $error("first row total differs from its dot product");

endmodule

bind matrix_vector_multiply_top mvm_checker u_mvm_checker (.*);

// ----- tb/matrix_vector_multiply_top_tb.sv -----
// Self-checking testbench for matrix_vector_multiply_top: vector loads and streamed matrix
// elements go in under several dim_n settings, and each row result is checked against a
// predictor kept in step with every transaction. Depends on mvm_pkg and the RTL only.
`timescale 1ns / 1ps
module matrix_vector_multiply_top_tb;
  import mvm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [2:0] DIM_ADDR = {REG_DIM, 2'b00};

  typedef struct {
    logic             func;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } elem_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [DATA_W-1:0] dot;
    logic [DATA_W-1:0] total;
    logic              last;
  } row_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_func = FUNC_LOAD;
  logic [IDX_W-1:0]  in_vector_index = '0;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic [IDX_W-1:0]  out_row_index;
  logic [DATA_W-1:0] out_dot_product;
  logic [DATA_W-1:0] out_total_sum;
  logic              out_last_row;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  matrix_vector_multiply_top dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [DATA_W-1:0] vec_mem [MAX_DIM_DEF];
  logic [DATA_W-1:0] row_acc = '0;
  logic [DATA_W-1:0] run_total = '0;
  int unsigned       col_cnt = 0;
  int unsigned       row_cnt = 0;
  logic [DIM_W-1:0]  dim_reg = DIM_RESET;

  elem_t       elem_q [$];
  row_result_t row_q [$];

  int errors = 0;
  int items_done = 0;
  int rows_checked = 0;
  int cfg_writes = 0;
  int idle_pct = 25;
  int cycles = 0;

  function automatic int unsigned active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM_DEF) return MAX_DIM_DEF;
    return dim_reg;
  endfunction

  function automatic void clear_progress();
    row_acc = '0;
    run_total = '0;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic void mac_element(logic func, logic [IDX_W-1:0] idx,
                                      logic [DATA_W-1:0] value);
    row_result_t r;
    int unsigned n;
    n = active_dim();
    if (func == FUNC_LOAD) begin
      vec_mem[idx] = value;
      return;
    end
    if (col_cnt >= MAX_DIM_DEF) col_cnt = 0;
    row_acc = row_acc + value * vec_mem[col_cnt];
    col_cnt++;
    if (col_cnt < n) return;
    run_total = run_total + row_acc;
    r.row = row_cnt[IDX_W-1:0];
    r.dot = row_acc;
    r.total = run_total;
    r.last = (row_cnt + 1 >= n);
    row_q.push_back(r);
    row_acc = '0;
    col_cnt = 0;
    if (r.last) begin
      row_cnt = 0;
      run_total = '0;
    end else begin
      row_cnt++;
    end
  endfunction

  function automatic string fmt_row(row_result_t r);
    return $sformatf("row=%0d dot=%h total=%h last=%b", r.row, r.dot, r.total, r.last);
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return DATA_W'($signed($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_elem(logic func, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    elem_t e;
    e.func = func;
    e.idx = idx;
    e.value = v;
    elem_q.push_back(e);
  endfunction

  // driver
  always @(posedge clk) begin
    elem_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        mac_element(in_func, in_vector_index, in_value);
        items_done++;
      end
      if (!start || !busy) begin
        if (elem_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = elem_q.pop_front();
          start <= 1'b1;
          in_func <= nxt.func;
          in_vector_index <= nxt.idx;
          in_value <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    row_result_t got, want;
    if (rst_n && out_valid) begin
      got.row = out_row_index;
      got.dot = out_dot_product;
      got.total = out_total_sum;
      got.last = out_last_row;
      rows_checked++;
      if (row_q.size() == 0) begin
        flag_error({"unexpected result ", fmt_row(got)});
      end else begin
        want = row_q.pop_front();
        if (got !== want)
          flag_error({"expected ", fmt_row(want), " got ", fmt_row(got)});
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (elem_q.size() != 0 || start || row_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_dim(logic [DIM_W-1:0] dim);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= DIM_ADDR;
    cfg_pwdata <= 32'(dim);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    dim_reg = dim;
    clear_progress();
    cfg_writes++;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[DIM_W-1:0] !== dim)
      flag_error($sformatf("dim_n readback expected %0d got %0d", dim, cfg_prdata[DIM_W-1:0]));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    logic [DIM_W-1:0] dims [12] = '{4'd8, 4'd1, 4'd0, 4'd2, 4'd15, 4'd3,
                                    4'd8, 4'd5, 4'd7, 4'd4, 4'd6, 4'd1};
    logic [DATA_W-1:0] edge_vals [8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                                         32'h1, 32'h2, 32'hFFFF_FFFE, 32'h5};
    int unsigned n;
    int unsigned elems;
    int unsigned target;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fill every vector entry, then rows under the reset dimension
    for (int i = 0; i < MAX_DIM_DEF; i++) push_elem(FUNC_LOAD, IDX_W'(i), edge_vals[i]);
    for (int i = 0; i < MAX_DIM_DEF; i++) push_elem(FUNC_MATRIX, '0, edge_vals[7 - i]);
    for (int i = 0; i < 3; i++) push_elem(FUNC_MATRIX, '0, 32'h8000_0000);
    push_elem(FUNC_LOAD, 3'd3, 32'h7);   // vector update mid-row
    for (int i = 0; i < 5; i++) push_elem(FUNC_MATRIX, '0, 32'h7FFF_FFFF);
    wait_idle();

    foreach (dims[p]) begin
      write_dim(dims[p]);
      n = (dims[p] == 0) ? 1 : (dims[p] > MAX_DIM_DEF) ? MAX_DIM_DEF : dims[p];
      target = n * n * (((36 / (n * n)) > 0) ? (36 / (n * n)) : 1);
      elems = 0;
      while (elems < target) begin
        if ($urandom_range(9) == 0) begin
          push_elem(FUNC_LOAD, IDX_W'($urandom_range(MAX_DIM_DEF - 1)), pick_value());
        end else begin
          push_elem(FUNC_MATRIX, IDX_W'($urandom), pick_value());
          elems++;
        end
      end
      // broken tail: up to n extra elements, any partial matrix cut off by the next dim_n write
      repeat ($urandom_range(n)) push_elem(FUNC_MATRIX, IDX_W'($urandom), pick_value());
      while (elem_q.size() != 0) begin
        @(negedge clk);
        idle_pct = (items_done < 200) ? 25 : (items_done < 400) ? 63 : 0;
      end
      wait_idle();
    end

    errors += row_q.size();
    $display("covered %0d transactions, %0d row results, %0d dim_n writes incl. 0 and 15",
             items_done, rows_checked, cfg_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mvm_pkg.sv
rtl/mvm_mac.sv
rtl/matrix_vector_multiply_top.sv
rtl/mvm_checker.sv
tb/matrix_vector_multiply_top_tb.sv
